// ----- design/bde_pkg.sv -----
// Package for the button debounce event block.
// Holds the configuration and sample types and the register map constants.
package bde_pkg;

  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int DEBOUNCE_W = 16;
  localparam int HOLD_W     = 32;

  localparam logic                  IDLE_LEVEL_RST = 1'b1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 16'd50;

  // register index: word address bit 2 of paddr
  localparam logic REG_IDLE_LEVEL = 1'b0;
  localparam logic REG_DEBOUNCE   = 1'b1;

  typedef struct packed {
    logic                  idle_level;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
  } bde_cfg_t;

  typedef struct packed {
    logic pin_level;
    logic clear_hold;
  } bde_sample_t;

endpackage

// ----- design/bde_if.sv -----
// Valid/ready channel interfaces for sample beats and event beats.
// Depends on bde_pkg for payload widths.
interface bde_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic clear_hold;

  modport source (output valid, output pin_level, output clear_hold, input ready);
  modport sink   (input valid, input pin_level, input clear_hold, output ready);
endinterface

interface bde_out_if;
  import bde_pkg::*;
  logic              valid;
  logic              ready;
  logic              push_event;
  logic              release_event;
  logic              pressed;
  logic [HOLD_W-1:0] hold_ticks;

  modport source (output valid, output push_event, output release_event,
                  output pressed, output hold_ticks, input ready);
  modport sink   (input valid, input push_event, input release_event,
                  input pressed, input hold_ticks, output ready);
endinterface

// ----- design/bde_cfg_regs.sv -----
// APB-style configuration registers: idle level and debounce time.
// Depends on bde_pkg.
module bde_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bde_pkg::ADDR_W-1:0] paddr,
  input  logic [bde_pkg::DATA_W-1:0] pwdata,
  output logic [bde_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bde_pkg::bde_cfg_t          cfg
);
  import bde_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_level     <= IDLE_LEVEL_RST;
      cfg.debounce_ticks <= DEBOUNCE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_IDLE_LEVEL: cfg.idle_level     <= pwdata[0];
        REG_DEBOUNCE:   cfg.debounce_ticks <= pwdata[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDLE_LEVEL: prdata = DATA_W'(cfg.idle_level);
      REG_DEBOUNCE:   prdata = DATA_W'(cfg.debounce_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- design/bde_in_stage.sv -----
// Input register for sample beats.
// Depends on bde_pkg and bde_in_if.
module bde_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  bde_in_if.sink                sample,
  input  logic                  advance,
  output logic                  s_valid,
  output bde_pkg::bde_sample_t  s_data
);
  import bde_pkg::*;

  assign sample.ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample.ready) begin
      s_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s_data.pin_level  <= sample.pin_level;
      s_data.clear_hold <= sample.clear_hold;
    end
  end

endmodule

// ----- design/bde_core.sv -----
// Debounce detectors, hold timer and result register.
// Depends on bde_pkg and bde_out_if.
module bde_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bde_pkg::bde_cfg_t    cfg,
  input  logic                 s_valid,
  input  bde_pkg::bde_sample_t s_data,
  output logic                 advance,
  bde_out_if.source            events
);
  import bde_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > DEBOUNCE_W) ? COUNT_WIDTH : DEBOUNCE_W;

  // on/off counters are shared by push, level and hold detectors: they
  // advance and clear on the same conditions
  logic                   push_latch, release_latch, pressed_level;
  logic                   hold_enabled, hold_started;
  logic [COUNT_WIDTH-1:0] on_count, off_count, hold_count;

  logic                   push_latch_next, release_latch_next, pressed_level_next;
  logic                   hold_enabled_next, hold_started_next;
  logic [COUNT_WIDTH-1:0] on_count_next, off_count_next, hold_count_next;

  logic                   active, hs_cleared, on_ge, off_ge, push_ev, rel_ev;
  logic [COUNT_WIDTH-1:0] on_inc, off_inc, hold_inc;
  logic [63:0]            hold_wide;
  logic [HOLD_W-1:0]      held;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  assign advance = s_valid && (!events.valid || events.ready);

  always_comb begin
    active     = s_data.pin_level != cfg.idle_level;
    hs_cleared = s_data.clear_hold ? 1'b0 : hold_started;
    on_inc     = sat_inc(on_count);
    off_inc    = sat_inc(off_count);
    hold_inc   = sat_inc(hold_count);
    on_ge      = CMP_W'(on_inc) >= CMP_W'(cfg.debounce_ticks);
    off_ge     = CMP_W'(off_inc) >= CMP_W'(cfg.debounce_ticks);

    push_ev            = active && !push_latch && on_ge;
    rel_ev             = !active && !release_latch && off_ge;
    push_latch_next    = active && (push_latch || push_ev);
    release_latch_next = !active && (release_latch || rel_ev);
    on_count_next      = active ? on_inc : '0;
    off_count_next     = active ? '0 : off_inc;

    pressed_level_next = pressed_level;
    hold_enabled_next  = hold_enabled;
    hold_started_next  = hs_cleared;
    if (active) begin
      if (!pressed_level && on_ge) pressed_level_next = 1'b1;
      if (!hold_enabled && on_ge) begin
        hold_enabled_next = 1'b1;
        hold_started_next = 1'b1;
      end
    end else begin
      if (pressed_level && off_ge) pressed_level_next = 1'b0;
      if (hold_enabled && off_ge) hold_enabled_next = 1'b0;
    end

    hold_count_next = (hold_started_next && hold_enabled_next) ? hold_inc : '0;
    hold_wide       = 64'(hold_count_next);
    held            = (hold_wide[63:HOLD_W] != '0) ? '1 : hold_wide[HOLD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_latch    <= 1'b0;
      release_latch <= 1'b1;
      pressed_level <= 1'b0;
      hold_enabled  <= 1'b0;
      hold_started  <= 1'b0;
      on_count      <= '0;
      off_count     <= '0;
      hold_count    <= '0;
    end else if (advance) begin
      push_latch    <= push_latch_next;
      release_latch <= release_latch_next;
      pressed_level <= pressed_level_next;
      hold_enabled  <= hold_enabled_next;
      hold_started  <= hold_started_next;
      on_count      <= on_count_next;
      off_count     <= off_count_next;
      hold_count    <= hold_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
    end else if (!events.valid || events.ready) begin
      events.valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      events.push_event    <= push_ev;
      events.release_event <= rel_ev;
      events.pressed       <= pressed_level_next;
      events.hold_ticks    <= held;
    end
  end

endmodule

// ----- design/button_debounce_events.sv -----
// Button debouncer with push/release pulses, debounced level and hold timer.
// Depends on bde_pkg, bde_if, bde_cfg_regs, bde_in_stage and bde_core.
//
// Usage:
//   sample: one beat per time-base tick, carrying the raw pin level and a
//           clear-hold request. Every sample beat yields exactly one beat
//           on events: push/release pulses, debounced pressed level and the
//           hold tick count (saturating, 0 when not holding).
//   APB:    reg 0 (addr 0) idle pin level, reg 1 (addr 4) debounce ticks.
//           Write only while no beats are in flight; pready is always high.
// A sample in the input register gives its event beat in the result
//   register, visible from then on. Throughput: one beat per cycle while
//   events is taken, set by the single register-to-register detector pass.
// Reset (synchronous, rst high): all detector counters and latches clear,
//   release latch sets, idle level goes to 1 and debounce time to 50 ticks.
// Stall: when events is not taken the result register holds; the input
//   register takes one more sample, then sample.ready drops until events
//   drains.
module button_debounce_events #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  bde_in_if.sink                     sample,
  bde_out_if.source                  events,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bde_pkg::ADDR_W-1:0] paddr,
  input  logic [bde_pkg::DATA_W-1:0] pwdata,
  output logic [bde_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bde_pkg::*;

  bde_cfg_t    cfg;
  bde_sample_t s_data;
  logic        s_valid;
  logic        advance;

  bde_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bde_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .advance (advance),
    .s_valid (s_valid),
    .s_data  (s_data)
  );

  bde_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .s_valid (s_valid),
    .s_data  (s_data),
    .advance (advance),
    .events  (events)
  );

endmodule

// ----- design/bde_checker.sv -----
// Port-level checks for button_debounce_events, attached by bind.
// Depends on the top level's event channel only.
module bde_checker (
  input logic        clk,
  input logic        rst,
  input logic        ev_valid,
  input logic        ev_push,
  input logic        ev_release,
  input logic        ev_pressed,
  input logic [31:0] ev_hold
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !ev_valid)
    else $error("event beat right after reset");

  a_push_pressed: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_push |-> ev_pressed && !ev_release)
    else $error("push pulse without pressed level");

  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_release |-> !ev_pressed)
    else $error("release pulse while pressed");

  a_hold_pressed: assert property (@(posedge clk) disable iff (rst)
    ev_valid && (ev_hold != 32'd0) |-> ev_pressed)
    else $error("hold count while not pressed");

endmodule

bind button_debounce_events bde_checker u_bde_checker (
  .clk        (clk),
  .rst        (rst),
  .ev_valid   (events.valid),
  .ev_push    (events.push_event),
  .ev_release (events.release_event),
  .ev_pressed (events.pressed),
  .ev_hold    (events.hold_ticks)
);

// ----- tb/button_debounce_events_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for button_debounce_events: a directed table, then random
// press/bounce/noise runs, with results checked against fixed values or a tick-accurate predictor.
// Depends on bde_pkg, bde_if and the button_debounce_events RTL.
module button_debounce_events_test;
  import bde_pkg::*;

  localparam int CW = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [ADDR_W-1:0] ADDR_IDLE = {REG_IDLE_LEVEL, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_DEB  = {REG_DEBOUNCE, 2'b00};

  typedef struct packed {
    logic              push;
    logic              rel;
    logic              pressed;
    logic [HOLD_W-1:0] hold;
  } tick_result_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic              pin;
    logic              clr;
    bit                fixed;
    tick_result_t      res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  bde_in_if  sample_ch ();
  bde_out_if event_ch ();

  button_debounce_events dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .events  (event_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic                  cfg_idle;
  logic [DEBOUNCE_W-1:0] cfg_deb;
  logic                  push_seen, rel_seen, lvl_q, hold_en, hold_run;
  logic [CW-1:0]         push_cnt, rel_cnt, lvl_on_cnt, lvl_off_cnt;
  logic [CW-1:0]         hold_on_cnt, hold_off_cnt, hold_cnt;

  tick_result_t pending_events[$];
  stim_row_t    dir_rows[$];
  int           errors = 0;
  int           beats_sent = 0;
  int           idle_cycles = 0;
  bit           calm = 1'b0;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic tick_result_t debounce_tick(input logic pin, input logic clr);
    tick_result_t r;
    logic act;
    r = '0;
    act = (pin != cfg_idle);
    if (clr) hold_run = 1'b0;
    push_cnt     = sat_inc(push_cnt);
    rel_cnt      = sat_inc(rel_cnt);
    lvl_on_cnt   = sat_inc(lvl_on_cnt);
    lvl_off_cnt  = sat_inc(lvl_off_cnt);
    hold_on_cnt  = sat_inc(hold_on_cnt);
    hold_off_cnt = sat_inc(hold_off_cnt);
    hold_cnt     = sat_inc(hold_cnt);

    if (act) begin
      if (!push_seen && push_cnt >= cfg_deb) begin
        r.push = 1'b1;
        push_seen = 1'b1;
      end
      rel_cnt = '0;
      rel_seen = 1'b0;
      if (!lvl_q && lvl_on_cnt >= cfg_deb) lvl_q = 1'b1;
      lvl_off_cnt = '0;
      if (!hold_en && hold_on_cnt >= cfg_deb) begin
        hold_en = 1'b1;
        hold_run = 1'b1;
      end
      hold_off_cnt = '0;
    end else begin
      push_cnt = '0;
      push_seen = 1'b0;
      if (!rel_seen && rel_cnt >= cfg_deb) begin
        r.rel = 1'b1;
        rel_seen = 1'b1;
      end
      if (lvl_q && lvl_off_cnt >= cfg_deb) lvl_q = 1'b0;
      lvl_on_cnt = '0;
      if (hold_en && hold_off_cnt >= cfg_deb) hold_en = 1'b0;
      hold_on_cnt = '0;
    end
    if (!hold_run || !hold_en) hold_cnt = '0;

    r.pressed = lvl_q;
    r.hold = (hold_en && hold_run) ? hold_cnt : '0;
    return r;
  endfunction

  function automatic stim_row_t beat_row(input logic pin, input logic clr);
    stim_row_t r;
    r = '{kind: ROW_BEAT, addr: '0, wdata: '0, pin: pin, clr: clr, fixed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input logic pin, input logic clr,
                                          input tick_result_t res);
    stim_row_t r;
    r = beat_row(pin, clr);
    r.fixed = 1'b1;
    r.res = res;
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] wdata);
    stim_row_t r;
    r = beat_row(1'b0, 1'b0);
    r.kind = ROW_WRITE;
    r.addr = addr;
    r.wdata = wdata;
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_beat(input logic pin, input logic clr, input bit fixed,
                           input tick_result_t res);
    tick_result_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.pin_level  <= pin;
    sample_ch.clear_hold <= clr;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = debounce_tick(pin, clr);
    pending_events.push_back(fixed ? res : predicted);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    sample_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_IDLE_LEVEL) cfg_idle = wdata[0];
    else cfg_deb = wdata[DEBOUNCE_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic rand_clr();
    return ($urandom_range(0, 9) == 0);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    tick_result_t e;
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t unexpected event beat: expected none actual hold=%0d", $realtime,
                 event_ch.hold_ticks);
        errors++;
      end else begin
        e = pending_events.pop_front();
        check_field("push_event", 32'(e.push), 32'(event_ch.push_event));
        check_field("release_event", 32'(e.rel), 32'(event_ch.release_event));
        check_field("pressed", 32'(e.pressed), 32'(event_ch.pressed));
        check_field("hold_ticks", e.hold, event_ch.hold_ticks);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    stall = 0;
    event_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        event_ch.ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        event_ch.ready <= 1'b0;
        stall = $urandom_range(1, 18) - 1;
      end else begin
        event_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned dd, plen, pstart, n;
    logic act_pin;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.pin_level = 1'b0;
    sample_ch.clear_hold = 1'b0;

    cfg_idle = IDLE_LEVEL_RST;
    cfg_deb = DEBOUNCE_RST;
    push_seen = 1'b0; rel_seen = 1'b1; lvl_q = 1'b0; hold_en = 1'b0; hold_run = 1'b0;
    push_cnt = '0; rel_cnt = '0; lvl_on_cnt = '0; lvl_off_cnt = '0;
    hold_on_cnt = '0; hold_off_cnt = '0; hold_cnt = '0;

    // after reset: idle high, 50-tick debounce
    dir_rows.push_back(fixed_row(1'b1, 1'b0, '{1'b0, 1'b0, 1'b0, 32'd0}));
    dir_rows.push_back(fixed_row(1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 32'd0}));
    // idle low, zero debounce; upper data bits ignored
    dir_rows.push_back(write_row(ADDR_IDLE, 32'hFFFF_FFFE));
    dir_rows.push_back(write_row(ADDR_DEB, 32'hFFFF_0000));
    dir_rows.push_back(fixed_row(1'b1, 1'b0, '{1'b1, 1'b0, 1'b1, 32'd1}));
    dir_rows.push_back(fixed_row(1'b1, 1'b0, '{1'b0, 1'b0, 1'b1, 32'd2}));
    dir_rows.push_back(fixed_row(1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 32'd0}));
    dir_rows.push_back(fixed_row(1'b0, 1'b0, '{1'b0, 1'b1, 1'b0, 32'd0}));
    dir_rows.push_back(fixed_row(1'b1, 1'b0, '{1'b1, 1'b0, 1'b1, 32'd1}));
    // longest debounce: nothing may fire
    dir_rows.push_back(write_row(ADDR_DEB, 32'hFFFF_FFFF));
    dir_rows.push_back(beat_row(1'b0, 1'b1));
    dir_rows.push_back(beat_row(1'b1, 1'b0));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    // idle high, 2-tick debounce, bouncy press with clear during hold
    dir_rows.push_back(write_row(ADDR_IDLE, 32'h0000_0003));
    dir_rows.push_back(write_row(ADDR_DEB, 32'h8000_0002));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(beat_row(1'b1, 1'b0));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(beat_row(1'b0, 1'b1));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(beat_row(1'b1, 1'b0));
    dir_rows.push_back(beat_row(1'b0, 1'b0));
    dir_rows.push_back(beat_row(1'b1, 1'b0));
    dir_rows.push_back(beat_row(1'b1, 1'b0));
    dir_rows.push_back(beat_row(1'b1, 1'b0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain();
        reg_write(dir_rows[i].addr, dir_rows[i].wdata);
      end else begin
        send_beat(dir_rows[i].pin, dir_rows[i].clr, dir_rows[i].fixed, dir_rows[i].res);
      end
    end

    for (int p = 0; p < 8; p++) begin
      drain();
      reg_write(ADDR_IDLE, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0} |
                           32'($urandom_range(0, 1)));
      case (p)
        0: dd = 0;
        1: dd = 1;
        2: dd = 16'hFFFF;
        3: dd = $urandom_range(2, 4);
        7: dd = $urandom_range(20, 40);
        default: dd = $urandom_range(0, 10);
      endcase
      reg_write(ADDR_DEB, {16'($urandom), 16'(dd)});
      plen = (dd == 16'hFFFF) ? 30 : 160;
      if (dd > 40) dd = 40;
      pstart = beats_sent;
      while (beats_sent - pstart < plen) begin
        calm = (p == 7) || ($urandom_range(0, 3) == 0);
        act_pin = ~cfg_idle;
        if ($urandom_range(0, 4) == 0) begin
          n = $urandom_range(1, 10);
          repeat (n) send_beat(1'($urandom_range(0, 1)), rand_clr(), 1'b0, '0);
        end else begin
          repeat ($urandom_range(0, 4)) send_beat(1'($urandom_range(0, 1)), rand_clr(), 1'b0, '0);
          repeat ($urandom_range(0, 3 * dd + 8)) send_beat(act_pin, rand_clr(), 1'b0, '0);
          repeat ($urandom_range(0, 4)) send_beat(1'($urandom_range(0, 1)), rand_clr(), 1'b0, '0);
          repeat ($urandom_range(0, 2 * dd + 6)) send_beat(~act_pin, rand_clr(), 1'b0, '0);
        end
      end
    end

    sample_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
